// ===== hw/rtl/per_client_rate_limiter_lru_core_assert.svh =====
// assertion macros for the port-level checker file
// depends on nothing; included by the checker module
`ifndef PER_CLIENT_RATE_LIMITER_LRU_CORE_ASSERT_SVH
`define PER_CLIENT_RATE_LIMITER_LRU_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define PRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/prl_pkg.sv =====
// shared types and constants for the rate limiter core
// depends on nothing
`timescale 1ns / 1ps
package prl_pkg;
    localparam logic [1:0] CFG_ACCESS_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BURST_WINDOW = 2'd1;
    localparam logic [1:0] CFG_LOCKOUT_TIME = 2'd2;
    localparam logic [15:0] RST_ACCESS_LIMIT = 16'd5;
    localparam logic [15:0] RST_BURST_WINDOW = 16'd20;
    localparam logic [15:0] RST_LOCKOUT_TIME = 16'd20;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // per-slot record held in the table memory
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] count;
        logic [31:0] last_seen;
        logic        locked;
        logic [31:0] unlock_at;
    } t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;
endpackage

// ===== hw/rtl/prl_ram.sv =====
// generic single-port-write, one-read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps
module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/per_client_rate_limiter_lru_core.sv =====
// per-client rate limiter core with an lru client table
// depends on prl_pkg and prl_ram
`timescale 1ns / 1ps
// One connection is taken per start beat while busy is low. The core scans
// the table memory one slot per cycle (address tags and recency ranks are in
// flip-flops, the per-client record in a RAM with registered read), then
// updates the record. The o_done strobe is registered in the update state,
// and busy drops together with it, so the next start beat can be taken while
// o_done is high. The result is shown for one cycle on o_done and cannot be
// held off by the receiver.
module per_client_rate_limiter_lru_core #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_client_addr,
    input  logic [31:0] i_now_seconds,
    output logic        o_done,
    output logic        o_limited,
    output logic        o_was_known,
    output logic        o_evicted,
    output logic [15:0] o_access_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import prl_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    logic [15:0] r_access_limit, r_burst_window, r_lockout_time;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [RW-1:0] r_rank [TABLE_ENTRIES];
    logic [31:0] r_tag [TABLE_ENTRIES];
    logic [31:0] r_addr, r_now;
    logic [IW-1:0] r_idx;
    logic r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic r_free, n_free;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [RW-1:0] r_worst;
    logic [IW-1:0] r_worst_idx;
    logic r_first;
    logic r_done, r_limited, r_known, r_evicted;
    logic [15:0] r_count;

    t_slot rd_slot, wr_slot;
    logic we;
    logic [IW-1:0] waddr;

    prl_ram #(.WIDTH($bits(t_slot)), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_slot),
        .i_raddr(n_hit_idx),
        .o_rdata(rd_slot)
    );

    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_done = r_done;
    assign o_limited = r_limited;
    assign o_was_known = r_known;
    assign o_evicted = r_evicted;
    assign o_access_count = r_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_limit <= RST_ACCESS_LIMIT;
            r_burst_window <= RST_BURST_WINDOW;
            r_lockout_time <= RST_LOCKOUT_TIME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACCESS_LIMIT: r_access_limit <= i_cfg_data;
                CFG_BURST_WINDOW: r_burst_window <= i_cfg_data;
                CFG_LOCKOUT_TIME: r_lockout_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan compare of the current slot
    logic cur_match, cur_free;
    always_comb begin
        cur_match = r_valid[r_idx] && (r_tag[r_idx] == r_addr);
        cur_free = !r_valid[r_idx];
        n_hit = r_hit;
        n_hit_idx = r_hit_idx;
        n_free = r_free;
        n_free_idx = r_free_idx;
        if (r_state == ST_SCAN) begin
            if (cur_match && !r_hit) begin
                n_hit = 1'b1;
                n_hit_idx = r_idx;
            end
            if (cur_free && !r_free) begin
                n_free = 1'b1;
                n_free_idx = r_idx;
            end
        end
    end

    // per-client decision on the hit record
    logic [31:0] d_unlock, d_seen;
    logic        h_limited;
    t_slot       h_slot;
    logic [15:0] base_cnt;
    always_comb begin
        d_unlock = r_now - rd_slot.unlock_at;
        d_seen = r_now - rd_slot.last_seen;
        h_slot = rd_slot;
        h_limited = 1'b0;
        base_cnt = rd_slot.count;
        if (rd_slot.locked) begin
            if (!d_unlock[31] && (d_unlock != 32'd0)) begin
                h_slot.locked = 1'b0;
                h_slot.unlock_at = 32'd0;
                base_cnt = 16'd1;
            end else begin
                h_limited = 1'b1;
            end
        end else if (rd_slot.count >= r_access_limit) begin
            if (d_seen[31] || (d_seen <= {16'd0, r_burst_window})) begin
                h_slot.locked = 1'b1;
                h_slot.unlock_at = r_now + {16'd0, r_lockout_time};
                h_limited = 1'b1;
            end
        end
        h_slot.count = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 16'd1;
        h_slot.last_seen = r_now;
    end

    // write-back selection
    logic [IW-1:0] target;
    always_comb begin
        target = r_free ? r_free_idx : r_worst_idx;
        we = (r_state == ST_UPDATE);
        waddr = r_hit ? r_hit_idx : target;
        if (r_hit) begin
            wr_slot = h_slot;
        end else begin
            wr_slot.addr = r_addr;
            wr_slot.count = 16'd1;
            wr_slot.last_seen = r_now;
            wr_slot.locked = 1'b0;
            wr_slot.unlock_at = 32'd0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_SCAN;
            ST_SCAN:   if (r_idx == LAST) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan bookkeeping, tags, ranks and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_addr <= i_client_addr;
                        r_now <= i_now_seconds;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_free <= 1'b0;
                        r_first <= 1'b1;
                        r_worst <= '0;
                        r_worst_idx <= '0;
                    end
                end
                ST_SCAN: begin
                    r_hit <= n_hit;
                    r_hit_idx <= n_hit_idx;
                    r_free <= n_free;
                    r_free_idx <= n_free_idx;
                    r_first <= 1'b0;
                    if (r_first || r_rank[r_idx] >= r_worst) begin
                        r_worst <= r_rank[r_idx];
                        r_worst_idx <= r_idx;
                    end
                    if (r_idx != LAST) r_idx <= r_idx + 1'b1;
                end
                ST_UPDATE: begin
                    r_done <= 1'b1;
                    r_known <= r_hit;
                    if (r_hit) begin
                        r_limited <= h_limited;
                        r_evicted <= 1'b0;
                        r_count <= h_slot.count;
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (IW'(i) != r_hit_idx && r_valid[i]
                                && r_rank[i] < r_rank[r_hit_idx]) begin
                                r_rank[i] <= r_rank[i] + 1'b1;
                            end
                        end
                        r_rank[r_hit_idx] <= '0;
                    end else begin
                        r_limited <= 1'b0;
                        r_evicted <= !r_free;
                        r_count <= 16'd1;
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (r_valid[i] && IW'(i) != target) begin
                                r_rank[i] <= r_rank[i] + 1'b1;
                            end
                        end
                        r_rank[target] <= '0;
                        r_valid[target] <= 1'b1;
                        r_tag[target] <= r_addr;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hw/rtl/prl_checker.sv =====
// port-level checker for the rate limiter core, bound to the core module
// depends on per_client_rate_limiter_lru_core_assert.svh
`timescale 1ns / 1ps
`include "per_client_rate_limiter_lru_core_assert.svh"
module prl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_limited,
    input logic        o_was_known,
    input logic        o_evicted,
    input logic [15:0] o_access_count
);
    // a beat taken makes the core busy next cycle
    `PRL_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // a miss is never limited
    `PRL_ASSERT_IMPL(a_miss_free, i_clk, i_rst_n, o_done && !o_was_known, !o_limited)
    // a hit never evicts
    `PRL_ASSERT_IMPL(a_hit_noevict, i_clk, i_rst_n, o_done && o_was_known, !o_evicted)
    // results come back with a nonzero count
    `PRL_ASSERT_IMPL(a_count_nz, i_clk, i_rst_n, o_done, o_access_count != 16'd0)
endmodule

bind per_client_rate_limiter_lru_core prl_checker u_prl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_limited(o_limited), .o_was_known(o_was_known),
    .o_evicted(o_evicted), .o_access_count(o_access_count)
);

// ===== test/per_client_rate_limiter_lru_core_checker.sv =====
// checker for the rate limiter core: predicts each connection result and compares
// depends on prl_pkg; watches the start, done and config channels of the core
`timescale 1ns / 1ps
module per_client_rate_limiter_lru_core_checker #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_client_addr,
    input  logic [31:0] i_now_seconds,
    input  logic        o_done,
    input  logic        o_limited,
    input  logic        o_was_known,
    input  logic        o_evicted,
    input  logic [15:0] o_access_count,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    import prl_pkg::*;

    typedef struct packed {
        logic        limited;
        logic        was_known;
        logic        evicted;
        logic [15:0] count;
    } t_verdict;

    t_verdict verdict_q[$];

    logic [15:0] lim_reg, win_reg, lock_reg;
    logic        tbl_valid  [TABLE_ENTRIES];
    logic [31:0] tbl_addr   [TABLE_ENTRIES];
    logic [15:0] tbl_count  [TABLE_ENTRIES];
    logic [31:0] tbl_seen   [TABLE_ENTRIES];
    logic        tbl_locked [TABLE_ENTRIES];
    logic [31:0] tbl_unlock [TABLE_ENTRIES];
    int          tbl_rank   [TABLE_ENTRIES];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // advance the client table by one connection and return the verdict
    function automatic t_verdict admit_client(input logic [31:0] addr,
                                              input logic [31:0] now);
        t_verdict v;
        int hit;
        int tgt;
        int old_rank;
        int worst;
        v = '0;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && tbl_valid[i] && tbl_addr[i] == addr) hit = i;
        if (hit >= 0) begin
            old_rank = tbl_rank[hit];
            if (tbl_locked[hit]) begin
                if ($signed(now - tbl_unlock[hit]) > 0) begin
                    tbl_locked[hit] = 1'b0;
                    tbl_unlock[hit] = '0;
                    tbl_count[hit] = 16'd1;
                end else begin
                    v.limited = 1'b1;
                end
            end else if (tbl_count[hit] >= lim_reg) begin
                if ($signed(now - tbl_seen[hit]) <= $signed({16'd0, win_reg})) begin
                    tbl_locked[hit] = 1'b1;
                    tbl_unlock[hit] = now + {16'd0, lock_reg};
                    v.limited = 1'b1;
                end
            end
            if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
            tbl_seen[hit] = now;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (i != hit && tbl_valid[i] && tbl_rank[i] < old_rank) tbl_rank[i]++;
            tbl_rank[hit] = 0;
            v.was_known = 1'b1;
            v.count = tbl_count[hit];
        end else begin
            tgt = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (tgt < 0 && !tbl_valid[i]) tgt = i;
            if (tgt < 0) begin
                worst = 0;
                tgt = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_rank[i] >= worst) begin
                        worst = tbl_rank[i];
                        tgt = i;
                    end
                tbl_valid[tgt] = 1'b0;
                v.evicted = 1'b1;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (tbl_valid[i]) tbl_rank[i]++;
            tbl_valid[tgt] = 1'b1;
            tbl_addr[tgt] = addr;
            tbl_count[tgt] = 16'd1;
            tbl_seen[tgt] = now;
            tbl_locked[tgt] = 1'b0;
            tbl_unlock[tgt] = '0;
            tbl_rank[tgt] = 0;
            v.count = 16'd1;
        end
        return v;
    endfunction

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    assign o_pending = verdict_q.size();

    // watch the channels, predict and compare
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            lim_reg <= RST_ACCESS_LIMIT;
            win_reg <= RST_BURST_WINDOW;
            lock_reg <= RST_LOCKOUT_TIME;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_rank[i] = 0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ACCESS_LIMIT: lim_reg <= i_cfg_data;
                    CFG_BURST_WINDOW: win_reg <= i_cfg_data;
                    CFG_LOCKOUT_TIME: lock_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                verdict_q.push_back(admit_client(i_client_addr, i_now_seconds));
            if (o_done) begin
                o_result_count++;
                if (verdict_q.size() == 0) begin
                    $display("unexpected result beat at %0t", $time);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_limited !== want.limited)
                        report_mismatch("limited", {15'd0, o_limited},
                                        {15'd0, want.limited});
                    if (o_was_known !== want.was_known)
                        report_mismatch("was_known", {15'd0, o_was_known},
                                        {15'd0, want.was_known});
                    if (o_evicted !== want.evicted)
                        report_mismatch("evicted", {15'd0, o_evicted},
                                        {15'd0, want.evicted});
                    if (o_access_count !== want.count)
                        report_mismatch("access_count", o_access_count, want.count);
                end
            end
        end
    end
endmodule

// ===== test/per_client_rate_limiter_lru_core_tb.sv =====
// testbench top for the rate limiter core: drives connections and config writes
// depends on prl_pkg, the core and per_client_rate_limiter_lru_core_checker
`timescale 1ns / 1ps
module per_client_rate_limiter_lru_core_tb;
    import prl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_client_addr;
    logic [31:0] i_now_seconds;
    logic        o_done;
    logic        o_limited;
    logic        o_was_known;
    logic        o_evicted;
    logic [15:0] o_access_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          result_count;
    int          idle_cycles;
    int          conn_sent;
    int          cfg_sent;
    logic [31:0] clock_now;
    logic [31:0] client_pool [16];

    per_client_rate_limiter_lru_core dut (.*);

    per_client_rate_limiter_lru_core_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_client_addr(i_client_addr), .i_now_seconds(i_now_seconds),
        .o_done(o_done), .o_limited(o_limited), .o_was_known(o_was_known),
        .o_evicted(o_evicted), .o_access_count(o_access_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles with no accepted beat or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge i_clk);
    endtask

    // one connection beat, held until accepted
    task automatic send_conn(input logic [31:0] addr, input logic [31:0] now);
        start <= 1'b1;
        i_client_addr <= addr;
        i_now_seconds <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        conn_sent++;
        @(posedge i_clk);
    endtask

    // config write issued only while the core is idle
    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_sent++;
    endtask

    task automatic random_phase(input int n);
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) a = $urandom();
            else a = client_pool[$urandom_range(0, 15)];
            case ($urandom_range(0, 9))
                0: clock_now = clock_now - $urandom_range(0, 30);
                1: clock_now = clock_now + $urandom_range(0, 70000);
                2: clock_now = $urandom();
                default: clock_now = clock_now + $urandom_range(0, 4);
            endcase
            send_conn(a, clock_now);
            if ($urandom_range(0, 2) == 0) random_gap();
        end
    endtask

    initial begin
        start = 1'b0;
        i_client_addr = '0;
        i_now_seconds = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ACCESS_LIMIT;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        idle_cycles = 0;
        conn_sent = 0;
        cfg_sent = 0;
        clock_now = 32'hFFFF_FFF0;
        for (int i = 0; i < 16; i++) client_pool[i] = $urandom();
        client_pool[0] = 32'h0;
        client_pool[1] = 32'hFFFF_FFFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, lockout, expiry across time wrap, negative gap
        for (int i = 0; i < 7; i++) send_conn(32'h0, clock_now + i);
        send_conn(32'h0, clock_now + 40);
        send_conn(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_conn(32'hFFFF_FFFF, 32'h0);
        for (int i = 0; i < 11; i++) send_conn(32'hC0A8_0000 + i, 32'd100);
        send_conn(32'h0, 32'd50);

        // extreme settings, then random phases over several settings
        write_cfg(CFG_ACCESS_LIMIT, 16'd1);
        write_cfg(CFG_BURST_WINDOW, 16'hFFFF);
        write_cfg(CFG_LOCKOUT_TIME, 16'd0);
        random_phase(200);
        write_cfg(CFG_ACCESS_LIMIT, 16'hFFFF);
        write_cfg(CFG_BURST_WINDOW, 16'd0);
        write_cfg(CFG_LOCKOUT_TIME, 16'hFFFF);
        for (int i = 0; i < 40; i++) send_conn(32'h0, clock_now);
        random_phase(150);
        write_cfg(CFG_ACCESS_LIMIT, 16'd0);
        write_cfg(CFG_LOCKOUT_TIME, 16'd3);
        random_phase(150);
        write_cfg(2'd3, 16'($urandom()));
        write_cfg(CFG_ACCESS_LIMIT, 16'($urandom_range(2, 8)));
        write_cfg(CFG_BURST_WINDOW, 16'($urandom_range(1, 30)));
        write_cfg(CFG_LOCKOUT_TIME, 16'($urandom_range(1, 30)));
        random_phase(400);

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("covered %0d connections, %0d results, %0d register writes",
                 conn_sent, result_count, cfg_sent);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
